@@ rtl/planar_span_raster_engine_unit_defines.svh @@
// Assertion macros shared by the checker of the planar span raster engine.
// No dependencies; included by the files that carry assertions.
`ifndef PLANAR_SPAN_RASTER_ENGINE_UNIT_DEFINES_SVH
`define PLANAR_SPAN_RASTER_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define PSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/psr_pkg.sv @@
// Shared types and constants of the planar span raster engine.
// No dependencies; used by the front end, the command queue, the drawing engine and the top level.
package psr_pkg;

    localparam int PIX_W  = 10;
    localparam int ROW_W  = 10;
    localparam int ADDR_W = 17;

    typedef enum logic [2:0] {
        OP_POINT  = 3'd0,
        OP_SPAN   = 3'd1,
        OP_SHADOW = 3'd2,
        OP_RECT   = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_FILL,
        K_SHADOW,
        K_CLEAR,
        K_READ
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [PIX_W-1:0]   lo;
        logic [PIX_W-1:0]   hi;
        logic [ADDR_W-1:0]  row_base;
        logic [ROW_W-1:0]   rows;
        logic [3:0]         colour;
        logic               prio;
        logic [63:0]        shadow_map;
    } cmd_t;

    typedef enum logic [2:0] {
        B_SWEEP,
        B_IDLE,
        B_RD,
        B_MOD,
        B_CLR,
        B_RDX,
        B_RDD,
        B_DONE
    } bstate_t;

endpackage

@@ rtl/psr_if.sv @@
// Channel interfaces of the planar span raster engine: request, result, config.
// No dependencies; the widths are written out in each interface.
interface psr_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] extent_x;
    logic signed [15:0] extent_y;
    logic [3:0]         colour;
    logic               set_priority;
    logic [63:0]        shadow_map;
    modport source (output valid, operation, coord_x, coord_y, extent_x, extent_y,
                    colour, set_priority, shadow_map, input ready);
    modport sink (input valid, operation, coord_x, coord_y, extent_x, extent_y,
                  colour, set_priority, shadow_map, output ready);
endinterface

interface psr_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] plane_word0;
    logic [15:0] plane_word1;
    logic [15:0] plane_word2;
    logic [15:0] plane_word3;
    logic [15:0] priority_word;
    logic        drew_pixels;
    modport source (output valid, plane_word0, plane_word1, plane_word2, plane_word3,
                    priority_word, drew_pixels, input ready);
    modport sink (input valid, plane_word0, plane_word1, plane_word2, plane_word3,
                  priority_word, drew_pixels, output ready);
endinterface

interface psr_cfg_if;
    logic valid;
    logic ready;
    logic shadow_mode_enabled;
    modport source (output valid, shadow_mode_enabled, input ready);
    modport sink (input valid, shadow_mode_enabled, output ready);
endinterface

@@ rtl/psr_front.sv @@
// Front end: accepts requests, clips them to the layer and classifies them.
// Depends on psr_pkg and the channel interfaces.
module psr_front
    import psr_pkg::*;
#(
    parameter int LAYER_WIDTH  = 320,
    parameter int LAYER_HEIGHT = 200
)(
    input  logic        clk,
    input  logic        rst_n,
    psr_item_if.sink    items,
    psr_cfg_if.sink     cfg,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        push_ready
);

    localparam int GPR = (LAYER_WIDTH + 15) / 16;
    localparam logic signed [17:0] WMAX = 18'(LAYER_WIDTH - 1);
    localparam logic signed [17:0] HMAX = 18'(LAYER_HEIGHT - 1);
    localparam logic signed [17:0] GMAX = 18'(GPR - 1);

    logic shadow_reg;
    logic shadow_next;

    logic signed [17:0] sx, sy, sex, sey;
    logic signed [17:0] xl, yl, wa, ha, hr, vr, lo, hi, y0, y1;
    logic               ok;
    kind_t              kind;

    assign cfg.ready   = 1'b1;
    assign items.ready = push_ready;
    assign push        = items.valid && push_ready;
    assign shadow_next = (cfg.valid) ? cfg.shadow_mode_enabled : shadow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= 1'b0;
        end
        else
        begin
            shadow_reg <= shadow_next;
        end
    end

    always_comb
    begin
        sx  = 18'(items.coord_x);
        sy  = 18'(items.coord_y);
        sex = 18'(items.extent_x);
        sey = 18'(items.extent_y);
        xl  = (sx < 0) ? 18'sd0 : sx;
        yl  = (sy < 0) ? 18'sd0 : sy;
        wa  = (sx < 0) ? sex + sx : sex;
        ha  = (sy < 0) ? sey + sy : sey;
        hr  = xl + wa - 18'sd1;
        vr  = yl + ha - 18'sd1;
        lo   = sx;
        hi   = sx;
        y0   = sy;
        y1   = sy;
        ok   = 1'b0;
        kind = K_NONE;
        unique case (items.operation)
            OP_POINT:
            begin
                ok   = sx >= 0 && sx <= WMAX && sy >= 0 && sy <= HMAX;
                kind = ok ? K_FILL : K_NONE;
            end
            OP_SPAN, OP_SHADOW:
            begin
                lo   = xl;
                hi   = (sex > WMAX) ? WMAX : sex;
                ok   = sy >= 0 && sy <= HMAX && lo <= hi;
                kind = !ok ? K_NONE :
                       (items.operation == OP_SHADOW && shadow_reg) ? K_SHADOW : K_FILL;
            end
            OP_RECT:
            begin
                lo   = xl;
                hi   = (hr > WMAX) ? WMAX : hr;
                y0   = yl;
                y1   = (vr > HMAX) ? HMAX : vr;
                ok   = hi >= lo && y1 >= y0;
                kind = ok ? K_FILL : K_NONE;
            end
            OP_CLEAR:
            begin
                y0   = 18'sd0;
                y1   = 18'sd0;
                kind = K_CLEAR;
            end
            OP_READ:
            begin
                ok   = sx >= 0 && sx <= GMAX && sy >= 0 && sy <= HMAX;
                kind = ok ? K_READ : K_NONE;
            end
            default:
            begin
                kind = K_NONE;
            end
        endcase
        push_cmd.kind       = kind;
        push_cmd.lo         = lo[PIX_W-1:0];
        push_cmd.hi         = hi[PIX_W-1:0];
        push_cmd.row_base   = ADDR_W'(y0[ROW_W-1:0] * GPR);
        push_cmd.rows       = ROW_W'(y1 - y0);
        push_cmd.colour     = items.colour;
        push_cmd.prio       = items.set_priority;
        push_cmd.shadow_map = items.shadow_map;
    end

endmodule

@@ rtl/psr_cmd_fifo.sv @@
// Two-entry command queue between the front end and the drawing engine.
// Depends on psr_pkg for the command type.
module psr_cmd_fifo
    import psr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output cmd_t head,
    output logic head_valid
);

    cmd_t       mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign push_ready = cnt_reg != 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign head       = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/psr_back.sv @@
// Drawing engine: owns the group memory and carries out queued commands.
// Depends on psr_pkg and the result interface.
module psr_back
    import psr_pkg::*;
#(
    parameter int LAYER_WIDTH  = 320,
    parameter int LAYER_HEIGHT = 200
)(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        head_valid,
    output logic        pop,
    psr_result_if.source results
);

    localparam int GPR = (LAYER_WIDTH + 15) / 16;
    localparam int GC  = GPR * LAYER_HEIGHT;
    localparam int AW  = (GC > 1) ? $clog2(GC) : 1;
    localparam int GW  = PIX_W - 4;

    bstate_t           state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [GW-1:0]     g_reg, g_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ROW_W-1:0]  rows_reg, rows_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [79:0]       rd_reg, rdata_reg, rd_next;
    logic              ov_reg, ov_next;
    logic [79:0]       out_reg, out_next;
    logic              od_reg, od_next;

    logic [79:0]       mem [GC];
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [79:0]       wdata;
    logic [15:0]       m;
    logic [15:0]       nw [4];
    logic [3:0]        v, nv;
    logic [ADDR_W-1:0] cur_addr;

    assign cur_addr = base_reg + ADDR_W'(g_reg);

    // Next state and register updates.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        g_next     = g_reg;
        base_next  = base_reg;
        rows_next  = rows_reg;
        clr_next   = clr_reg;
        rd_next    = rd_reg;
        ov_next    = ov_reg && !results.ready;
        out_next   = out_reg;
        od_next    = od_reg;
        unique case (state_reg)
            B_SWEEP, B_CLR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(GC - 1))
                begin
                    clr_next   = '0;
                    state_next = (state_reg == B_SWEEP) ? B_IDLE : B_DONE;
                end
            end
            B_IDLE:
            begin
                if (head_valid)
                begin
                    cmd_next  = head;
                    g_next    = head.lo[PIX_W-1:4];
                    base_next = head.row_base;
                    rows_next = head.rows;
                    rd_next   = '0;
                    unique case (head.kind)
                        K_FILL, K_SHADOW: state_next = B_RD;
                        K_CLEAR:          state_next = B_CLR;
                        K_READ:           state_next = B_RDX;
                        default:          state_next = B_DONE;
                    endcase
                end
            end
            B_RD:
            begin
                state_next = B_MOD;
            end
            B_MOD:
            begin
                state_next = B_RD;
                if (g_reg == cmd_reg.hi[PIX_W-1:4])
                begin
                    g_next = cmd_reg.lo[PIX_W-1:4];
                    if (rows_reg == '0)
                    begin
                        state_next = B_DONE;
                    end
                    else
                    begin
                        rows_next = rows_reg - 1'b1;
                        base_next = base_reg + ADDR_W'(GPR);
                    end
                end
                else
                begin
                    g_next = g_reg + 1'b1;
                end
            end
            B_RDX:
            begin
                state_next = B_RDD;
            end
            B_RDD:
            begin
                rd_next    = rdata_reg;
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!ov_reg || results.ready)
                begin
                    ov_next    = 1'b1;
                    out_next   = rd_reg;
                    od_next    = cmd_reg.kind == K_FILL || cmd_reg.kind == K_SHADOW ||
                                 cmd_reg.kind == K_CLEAR;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Memory controls and the new contents of a group.
    always_comb
    begin
        pop   = state_reg == B_IDLE && head_valid;
        we    = 1'b0;
        re    = 1'b0;
        waddr = clr_reg;
        raddr = cur_addr[AW-1:0];
        wdata = '0;
        v     = '0;
        nv    = '0;
        m     = 16'hFFFF;
        if (g_reg == cmd_reg.lo[PIX_W-1:4])
        begin
            m = m >> cmd_reg.lo[3:0];
        end
        if (g_reg == cmd_reg.hi[PIX_W-1:4])
        begin
            m = m & (16'hFFFF << (4'd15 - cmd_reg.hi[3:0]));
        end
        for (int k = 0; k < 4; k++)
        begin
            nw[k] = (rdata_reg[16*k +: 16] & ~m) | (cmd_reg.colour[k] ? m : 16'h0000);
        end
        if (cmd_reg.kind == K_SHADOW)
        begin
            for (int b = 0; b < 16; b++)
            begin
                v  = {rdata_reg[48+b], rdata_reg[32+b], rdata_reg[16+b], rdata_reg[b]};
                nv = cmd_reg.shadow_map[4*v +: 4];
                for (int k = 0; k < 4; k++)
                begin
                    nw[k][b] = m[b] ? nv[k] : rdata_reg[16*k+b];
                end
            end
        end
        unique case (state_reg)
            B_SWEEP:
            begin
                we = 1'b1;
            end
            B_CLR:
            begin
                we = 1'b1;
                wdata = {{16{cmd_reg.prio}}, {16{cmd_reg.colour[3]}}, {16{cmd_reg.colour[2]}},
                         {16{cmd_reg.colour[1]}}, {16{cmd_reg.colour[0]}}};
            end
            B_RD:
            begin
                re = 1'b1;
            end
            B_RDX:
            begin
                re    = 1'b1;
                raddr = AW'(cmd_reg.row_base + ADDR_W'(cmd_reg.lo));
            end
            B_MOD:
            begin
                we    = 1'b1;
                waddr = cur_addr[AW-1:0];
                wdata[63:0] = {nw[3], nw[2], nw[1], nw[0]};
                wdata[79:64] = (cmd_reg.kind == K_SHADOW || cmd_reg.prio) ?
                               (rdata_reg[79:64] | m) : (rdata_reg[79:64] & ~m);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_SWEEP;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        g_reg    <= g_next;
        base_reg <= base_next;
        rows_reg <= rows_next;
        rd_reg   <= rd_next;
        out_reg  <= out_next;
        od_reg   <= od_next;
    end

    assign results.valid         = ov_reg;
    assign results.plane_word0   = out_reg[15:0];
    assign results.plane_word1   = out_reg[31:16];
    assign results.plane_word2   = out_reg[47:32];
    assign results.plane_word3   = out_reg[63:48];
    assign results.priority_word = out_reg[79:64];
    assign results.drew_pixels   = od_reg;

endmodule

@@ rtl/planar_span_raster_engine_unit.sv @@
// Top level of the planar span raster engine.
// Depends on psr_pkg, the channel interfaces, psr_front, psr_cmd_fifo and psr_back.
//
// Usage: drawing requests enter on the items channel (valid/ready); each request
// yields exactly one result on the results channel, in request order. The single
// configuration register, shadow_mode_enabled, is written on the cfg channel,
// which is always ready; write it only while the engine is idle.
// The front end clips and classifies a request in the cycle it is accepted and
// places it in a two-entry queue, so up to two requests can wait while the
// drawing engine is busy. The engine performs a read-modify-write on the group
// memory, a read state (B_RD) and a write state (B_MOD) per 16-pixel group
// touched; a point, span or rectangle walks the groups of each row and then
// the rows in turn, a read group reads one word (B_RDX, B_RDD), and clear
// layer writes every group (B_CLR) with the request's colour and priority bit.
// After reset the engine clears all GROUPS_PER_ROW x LAYER_HEIGHT groups (4000
// at default size) of the memory to zero; requests are still queued then.
// A finished result waits in an output register; while the receiver stalls the
// engine keeps working on the next queued request and halts only when it has
// another result to hand over.
module planar_span_raster_engine_unit
    import psr_pkg::*;
#(
    parameter int LAYER_WIDTH  = 320,
    parameter int LAYER_HEIGHT = 200
)(
    input  logic          clk,
    input  logic          rst_n,
    psr_item_if.sink      items,
    psr_cfg_if.sink       cfg,
    psr_result_if.source  results
);

    cmd_t push_cmd;
    cmd_t head;
    logic push, push_ready, pop, head_valid;

    // Front end: clipping, classification and the configuration register.
    psr_front #(
        .LAYER_WIDTH  (LAYER_WIDTH),
        .LAYER_HEIGHT (LAYER_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cfg        (cfg),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // Queue that lets the front end and the engine stall independently.
    psr_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // Drawing engine with the group memory and the output register.
    psr_back #(
        .LAYER_WIDTH  (LAYER_WIDTH),
        .LAYER_HEIGHT (LAYER_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .results    (results)
    );

endmodule

@@ rtl/psr_checker.sv @@
// Port-level checker for the planar span raster engine, bound to the top level.
// Depends on planar_span_raster_engine_unit_defines.svh.
`include "planar_span_raster_engine_unit_defines.svh"

module psr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] w0,
    input logic [15:0] w1,
    input logic [15:0] w2,
    input logic [15:0] w3,
    input logic [15:0] pw,
    input logic        drew
);

    `PSR_ASSERT_NEXT(a_hold_valid, clk, rst_n, res_valid && !res_ready, res_valid)
    `PSR_ASSERT_NEXT(a_hold_drew, clk, rst_n, res_valid && !res_ready, $stable(drew))
    `PSR_ASSERT_NOW(a_draw_planes, clk, rst_n, res_valid && drew, (w0 | w1 | w2 | w3) == 16'h0)
    `PSR_ASSERT_NOW(a_draw_prio, clk, rst_n, res_valid && drew, pw == 16'h0)

endmodule

bind planar_span_raster_engine_unit psr_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .w0        (results.plane_word0),
    .w1        (results.plane_word1),
    .w2        (results.plane_word2),
    .w3        (results.plane_word3),
    .pw        (results.priority_word),
    .drew      (results.drew_pixels)
);
